@@ design/assert_macros.svh @@
// Assertion macros shared by the button release debouncer RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on clk, off while arst_n is low
`define BRD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk, off while arst_n is low
`define BRD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/brd_pkg.sv @@
// Types, codes and widths shared by the button release debouncer
`timescale 1ns / 1ps
package brd_pkg;

	localparam int TIME_W = 64;
	localparam int CFG_W  = 32;

	// event kinds
	localparam logic [1:0] FUNC_DOWN = 2'd0;
	localparam logic [1:0] FUNC_UP   = 2'd1;
	localparam logic [1:0] FUNC_EMIT = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_SHORT_THR = 2'd0;
	localparam logic [1:0] CFG_SHORT_WIN = 2'd1;
	localparam logic [1:0] CFG_NORM_WIN  = 2'd2;

	typedef enum logic [1:0] {
		ACT_PASS   = 2'd0,
		ACT_CANCEL = 2'd1,
		ACT_RETRY  = 2'd2,
		ACT_HOLD   = 2'd3
	} action_t;

	typedef struct packed {
		logic [CFG_W-1:0] short_thr;
		logic [CFG_W-1:0] short_win;
		logic [CFG_W-1:0] normal_win;
	} cfg_t;

	typedef struct packed {
		action_t           action;
		logic [TIME_W-1:0] deadline;
		logic              short_used;
	} result_t;

	// handshake between the front/back registers and the evaluation core
	typedef struct packed {
		logic take;   // item in the input register is consumed this cycle
		logic emit;   // and it loads the result register
	} core_ctl_t;

endpackage

@@ design/brd_cfg.sv @@
// Configuration register file of the button release debouncer
`timescale 1ns / 1ps
module brd_cfg
	import brd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	output cfg_t             cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SHORT_THR: cfg_q.short_thr  <= cfg_data;
				CFG_SHORT_WIN: cfg_q.short_win  <= cfg_data;
				CFG_NORM_WIN:  cfg_q.normal_win <= cfg_data;
				default: ;  // unmapped index, write dropped
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ design/brd_core.sv @@
// Debounce state and single-pass evaluation of one button event
`timescale 1ns / 1ps
`include "assert_macros.svh"
module brd_core
	import brd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              item_valid,
	input  logic [1:0]        item_func,
	input  logic [TIME_W-1:0] item_time,
	input  logic              out_free,
	output core_ctl_t         ctl,
	output result_t           res
);

	logic              up_pending_q;
	logic              pending_is_short_q;
	logic [TIME_W-1:0] pending_deadline_q;
	logic              down_seen_q;
	logic [TIME_W-1:0] last_down_time_q;

	logic              has_result;
	logic              early_down;
	logic [TIME_W-1:0] held;
	logic              is_short;
	logic [CFG_W-1:0]  win;
	logic [TIME_W-1:0] new_deadline;

	// press length; no prior down or time going backward counts as endless
	assign held     = item_time - last_down_time_q;
	assign is_short = down_seen_q && (item_time >= last_down_time_q)
		&& (held < {{(TIME_W-CFG_W){1'b0}}, cfg.short_thr});
	assign win          = is_short ? cfg.short_win : cfg.normal_win;
	assign new_deadline = item_time + {{(TIME_W-CFG_W){1'b0}}, win};  // wraps
	assign early_down   = item_time < pending_deadline_q;

	assign has_result = (item_func == FUNC_DOWN) || (item_func == FUNC_UP);
	assign ctl.take   = item_valid && (out_free || !has_result);
	assign ctl.emit   = ctl.take && has_result;

	always_comb begin
		res.action     = ACT_PASS;
		res.deadline   = '0;
		res.short_used = 1'b0;
		unique case (item_func)
			FUNC_DOWN: begin
				if (up_pending_q && !early_down) begin
					res.action     = ACT_RETRY;
					res.deadline   = pending_deadline_q;
					res.short_used = pending_is_short_q;
				end else if (up_pending_q) begin
					res.action = ACT_CANCEL;
				end
			end
			FUNC_UP: begin
				res.action     = ACT_HOLD;
				res.deadline   = new_deadline;
				res.short_used = is_short;
			end
			default: ;  // emitted or unused kinds give no result
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_pending_q       <= 1'b0;
			pending_is_short_q <= 1'b0;
			pending_deadline_q <= '0;
			down_seen_q        <= 1'b0;
			last_down_time_q   <= '0;
		end else if (ctl.take) begin
			unique case (item_func)
				FUNC_DOWN: begin
					if (!up_pending_q || early_down) begin
						up_pending_q       <= 1'b0;
						pending_is_short_q <= 1'b0;
						pending_deadline_q <= '0;
						down_seen_q        <= 1'b1;
						last_down_time_q   <= item_time;
					end
				end
				FUNC_UP: begin
					up_pending_q       <= 1'b1;
					pending_is_short_q <= is_short;
					pending_deadline_q <= new_deadline;
				end
				FUNC_EMIT: begin
					up_pending_q       <= 1'b0;
					pending_is_short_q <= 1'b0;
					pending_deadline_q <= '0;
				end
				default: ;
			endcase
		end
	end

	`BRD_ASSERT_NOW(a_idle_pending_clear, !up_pending_q,
		(pending_deadline_q == '0) && !pending_is_short_q, "stale pending up fields")
	`BRD_ASSERT_NEXT(a_up_sets_pending, ctl.take && (item_func == FUNC_UP),
		up_pending_q, "up did not arm the pending release")
	`BRD_ASSERT_NEXT(a_retry_keeps_state, ctl.emit && (res.action == ACT_RETRY),
		$stable(pending_deadline_q) && $stable(last_down_time_q) && up_pending_q,
		"retry changed debounce state")

endmodule

@@ design/button_release_debouncer_top.sv @@
// Top level of the button release debouncer: input register, core, result register
`timescale 1ns / 1ps
`include "assert_macros.svh"
// An accepted event beat waits in the input register; its result beat then loads
// the result register. Throughput: one event per cycle while the result register
//   is free; input and result registers are parted so an event is taken while
//   a result waits on res_ready. Emitted-up and unused kinds give no result beat.
// Reset (arst_n low, asynchronous): config registers zero, no pending up,
//   no down seen, both registers empty.
module button_release_debouncer_top
	import brd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// configuration
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	// event channel
	input  logic              evt_valid,
	output logic              evt_ready,
	input  logic [1:0]        func,
	input  logic [TIME_W-1:0] event_time_ns,
	// result channel
	output logic              res_valid,
	input  logic              res_ready,
	output logic [1:0]        action,
	output logic [TIME_W-1:0] release_deadline_ns,
	output logic              short_window_used
);

	cfg_t      cfg;
	core_ctl_t ctl;
	result_t   res;

	// input register
	logic              valid_s1;
	logic [1:0]        func_s1;
	logic [TIME_W-1:0] event_time_s1;

	// result register
	logic    res_valid_q;
	result_t res_q;
	logic    out_free;

	brd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	brd_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.item_valid (valid_s1),
		.item_func  (func_s1),
		.item_time  (event_time_s1),
		.out_free   (out_free),
		.ctl        (ctl),
		.res        (res)
	);

	// input register takes a beat when empty or when its item moves on
	assign evt_ready = !valid_s1 || ctl.take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt_ready) begin
			valid_s1 <= evt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt_valid && evt_ready) begin
			func_s1       <= func;
			event_time_s1 <= event_time_ns;
		end
	end

	// result register frees up in the same cycle its beat is taken
	assign out_free = !res_valid_q || res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= ctl.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			res_q <= res;
		end
	end

	assign res_valid           = res_valid_q;
	assign action              = res_q.action;
	assign release_deadline_ns = res_q.deadline;
	assign short_window_used   = res_q.short_used;

	`BRD_ASSERT_NOW(a_emit_has_room, ctl.emit, out_free,
		"result overwritten before it was taken")
	`BRD_ASSERT_NEXT(a_stalled_item_held, valid_s1 && !ctl.take,
		valid_s1 && $stable(event_time_s1) && $stable(func_s1),
		"stalled event lost from input register")

endmodule

@@ verif/button_release_debouncer_top_test.sv @@
// Self-checking testbench for the button release debouncer top level
`timescale 1ns / 1ps
module button_release_debouncer_top_test;
	import brd_pkg::*;

	// func 3 has no meaning; the block must drop it silently
	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	// directed rows that run under the reset register values
	localparam int RESET_CFG_ROWS = 4;
	// random beats per register setting, not counting unused kinds
	localparam int EVENTS_PER_SETTING = 100;
	localparam int SETTINGS_RUN = 6;
	// margin after the last expected beat before touching registers
	localparam int SETTLE_CYCLES = 4;
	// long receiver hold-off, enough to back up both internal registers
	localparam int BACKPRESSURE_CYCLES = 60;

	logic              clk;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [1:0]        cfg_index = CFG_SHORT_THR;
	logic [CFG_W-1:0]  cfg_data = '0;
	logic              evt_valid = 1'b0;
	logic              evt_ready;
	logic [1:0]        func = FUNC_DOWN;
	logic [TIME_W-1:0] event_time_ns = '0;
	logic              res_valid;
	logic              res_ready = 1'b0;
	logic [1:0]        action;
	logic [TIME_W-1:0] release_deadline_ns;
	logic              short_window_used;

	button_release_debouncer_top u_dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_we              (cfg_we),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data),
		.evt_valid           (evt_valid),
		.evt_ready           (evt_ready),
		.func                (func),
		.event_time_ns       (event_time_ns),
		.res_valid           (res_valid),
		.res_ready           (res_ready),
		.action              (action),
		.release_deadline_ns (release_deadline_ns),
		.short_window_used   (short_window_used)
	);

	// A directed row either carries a hand-written outcome (typed) or leaves
	// it to the predictor.
	typedef struct {
		logic [1:0]        kind;
		logic [TIME_W-1:0] stamp;
		bit                typed;
		result_t           want;
	} directed_row_t;

	// Per offered beat: whether its outcome was typed in, and that outcome
	typedef struct {
		bit      typed;
		result_t want;
	} beat_tag_t;

	localparam result_t NO_WANT = '{ACT_PASS, '0, 1'b0};

	// Rows 0..3 run with all registers at zero; from row 4 the setting is
	// threshold 1000, short window 50, normal window 500.
	directed_row_t directed_rows [24] = '{
		// up with no earlier down: infinitely long press, zero window
		'{FUNC_UP,     64'd5,   1'b1, '{ACT_HOLD,  64'd5, 1'b0}},
		// down exactly at the deadline asks for expiry first
		'{FUNC_DOWN,   64'd5,   1'b1, '{ACT_RETRY, 64'd5, 1'b0}},
		'{FUNC_EMIT,   64'd9,   1'b0, NO_WANT},
		'{FUNC_DOWN,   64'd0,   1'b1, '{ACT_PASS,  64'd0, 1'b0}},
		// short press, then a bounce inside the short window
		'{FUNC_UP,     64'd400, 1'b1, '{ACT_HOLD,  64'd450, 1'b1}},
		'{FUNC_DOWN,   64'd420, 1'b1, '{ACT_CANCEL, 64'd0, 1'b0}},
		'{FUNC_UP,     64'd2000, 1'b1, '{ACT_HOLD, 64'd2500, 1'b0}},
		// second up replaces the pending one
		'{FUNC_UP,     64'd2100, 1'b0, NO_WANT},
		'{FUNC_DOWN,   64'd2600, 1'b1, '{ACT_RETRY, 64'd2600, 1'b0}},
		'{FUNC_EMIT,   64'd2600, 1'b0, NO_WANT},
		'{FUNC_UNUSED, 64'd123,  1'b0, NO_WANT},
		'{FUNC_DOWN,   64'd2601, 1'b1, '{ACT_PASS, 64'd0, 1'b0}},
		// time ran backward: treated like no earlier down
		'{FUNC_UP,     64'd100,  1'b0, NO_WANT},
		'{FUNC_DOWN,   64'd599,  1'b0, NO_WANT},
		// one below the threshold, measured from the cancelled down
		'{FUNC_UP,     64'd1598, 1'b0, NO_WANT},
		'{FUNC_EMIT,   64'd0,    1'b0, NO_WANT},
		'{FUNC_DOWN,   64'hFFFF_FFFF_FFFF_FF00, 1'b1, '{ACT_PASS, 64'd0, 1'b0}},
		// deadline wraps past 2^64
		'{FUNC_UP,     64'hFFFF_FFFF_FFFF_FFF0, 1'b0, NO_WANT},
		'{FUNC_DOWN,   64'hFFFF_FFFF_FFFF_FFFF, 1'b0, NO_WANT},
		'{FUNC_EMIT,   64'd0,    1'b0, NO_WANT},
		'{FUNC_DOWN,   64'd0,    1'b1, '{ACT_PASS, 64'd0, 1'b0}},
		// press exactly at the threshold is not short
		'{FUNC_UP,     64'd1000, 1'b0, NO_WANT},
		'{FUNC_UP,     64'h5555_5555_5555_5555, 1'b0, NO_WANT},
		'{FUNC_DOWN,   64'hAAAA_AAAA_AAAA_AAAA, 1'b0, NO_WANT}
	};

	// Predictor copy of the registers and of the debouncer state
	logic [CFG_W-1:0]  thr_ns, short_win_ns, normal_win_ns;
	logic              up_pending, pending_short, down_seen;
	logic [TIME_W-1:0] pending_deadline, last_down_ns;

	result_t   outcome_q [$];
	beat_tag_t beat_tag_q [$];

	int sender_idle_pct = 0;
	int recv_stall_pct  = 0;
	int hold_off_cycles = 0;
	int events_taken    = 0;
	int outcomes_checked = 0;
	int mismatches      = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Ends a hung run; the slowest correct run is far shorter.
	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

	// Computes what one event beat produces and advances the predicted state.
	// Returns 0 when the event yields no result beat.
	function automatic bit debounce_event(input logic [1:0] kind,
	                                      input logic [TIME_W-1:0] stamp,
	                                      output result_t res);
		logic [TIME_W-1:0] held;
		res = NO_WANT;
		case (kind)
			FUNC_DOWN: begin
				if (up_pending && stamp >= pending_deadline) begin
					res.action = ACT_RETRY;
				end else begin
					// a bounced down still becomes the new press start
					res.action = up_pending ? ACT_CANCEL : ACT_PASS;
					up_pending = 1'b0;
					pending_short = 1'b0;
					pending_deadline = '0;
					down_seen = 1'b1;
					last_down_ns = stamp;
				end
			end
			FUNC_UP: begin
				held = '1;
				if (down_seen && stamp >= last_down_ns)
					held = stamp - last_down_ns;
				pending_short = held < {32'd0, thr_ns};
				up_pending = 1'b1;
				// wraps modulo 2^64
				pending_deadline = stamp + {32'd0, pending_short ? short_win_ns : normal_win_ns};
				res.action = ACT_HOLD;
			end
			FUNC_EMIT: begin
				up_pending = 1'b0;
				pending_short = 1'b0;
				pending_deadline = '0;
				return 1'b0;
			end
			default: return 1'b0;
		endcase
		res.deadline = up_pending ? pending_deadline : '0;
		res.short_used = up_pending && pending_short;
		return 1'b1;
	endfunction

	// Scoreboard: result beats are checked before the event beat of the same
	// edge is predicted, since a result always trails its event.
	always @(posedge clk) begin
		result_t   want;
		beat_tag_t tag;
		if (arst_n) begin
			if (res_valid && res_ready) begin
				if (outcome_q.size() == 0) begin
					$error("result beat with nothing expected: action %0d deadline %h",
						action, release_deadline_ns);
					mismatches++;
				end else begin
					want = outcome_q.pop_front();
					outcomes_checked++;
					if (action !== want.action) begin
						$error("action: expected %0d, got %0d", want.action, action);
						mismatches++;
					end
					if (release_deadline_ns !== want.deadline) begin
						$error("release_deadline_ns: expected %h, got %h",
							want.deadline, release_deadline_ns);
						mismatches++;
					end
					if (short_window_used !== want.short_used) begin
						$error("short_window_used: expected %0b, got %0b",
							want.short_used, short_window_used);
						mismatches++;
					end
				end
			end
			if (evt_valid && evt_ready) begin
				events_taken++;
				tag = beat_tag_q.pop_front();
				if (debounce_event(func, event_time_ns, want))
					outcome_q.push_back(tag.typed ? tag.want : want);
			end
		end
	end

	// Receiver: random stalls, or a counted hold-off when one is requested
	always @(posedge clk) begin
		if (hold_off_cycles > 0) begin
			res_ready <= 1'b0;
			hold_off_cycles <= hold_off_cycles - 1;
		end else begin
			res_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Offers one event beat, holds it until taken, then maybe idles.
	// Entered and left right after a rising edge.
	task automatic offer_event(input logic [1:0] kind, input logic [TIME_W-1:0] stamp,
	                           input bit typed, input result_t want);
		beat_tag_q.push_back('{typed, want});
		evt_valid <= 1'b1;
		func <= kind;
		event_time_ns <= stamp;
		do @(posedge clk); while (!evt_ready);
		if ($urandom_range(99) < sender_idle_pct) begin
			evt_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
		end
	endtask

	// Stops offering and waits until every expected beat is out
	task automatic settle();
		evt_valid <= 1'b0;
		while (outcome_q.size() != 0 || beat_tag_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_config(input logic [CFG_W-1:0] thr, sw, nw);
		cfg_we <= 1'b1;
		cfg_index <= CFG_SHORT_THR;
		cfg_data <= thr;
		@(posedge clk);
		cfg_index <= CFG_SHORT_WIN;
		cfg_data <= sw;
		@(posedge clk);
		cfg_index <= CFG_NORM_WIN;
		cfg_data <= nw;
		@(posedge clk);
		cfg_we <= 1'b0;
		thr_ns = thr;
		short_win_ns = sw;
		normal_win_ns = nw;
	endtask

	initial begin
		logic [1:0]        kind;
		logic [TIME_W-1:0] cursor_ns;
		logic [CFG_W-1:0]  thr, sw, nw, span;
		int                sent;

		thr_ns = '0;
		short_win_ns = '0;
		normal_win_ns = '0;
		up_pending = 1'b0;
		pending_short = 1'b0;
		pending_deadline = '0;
		down_seen = 1'b0;
		last_down_ns = '0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, back to back, no stalls
		for (int i = 0; i < $size(directed_rows); i++) begin
			if (i == RESET_CFG_ROWS) begin
				settle();
				load_config(32'd1000, 32'd50, 32'd500);
			end
			offer_event(directed_rows[i].kind, directed_rows[i].stamp,
				directed_rows[i].typed, directed_rows[i].want);
		end
		settle();

		cursor_ns = '0;
		for (int s = 0; s < SETTINGS_RUN; s++) begin
			case (s)
				0: begin thr = 32'd1000; sw = 32'd50; nw = 32'd500; end
				1: begin thr = '0; sw = '0; nw = '0; end
				2: begin thr = '1; sw = '1; nw = '1; end
				3: begin
					thr = $urandom_range(0, 5000);
					sw = $urandom_range(0, 2000);
					nw = $urandom_range(0, 8000);
				end
				4: begin thr = '1; sw = '0; nw = 32'd1; end
				default: begin thr = $urandom; sw = $urandom; nw = $urandom; end
			endcase
			load_config(thr, sw, nw);
			span = (thr > sw) ? thr : sw;
			span = (span > nw) ? span : nw;

			// flow-control mode rotates with the setting
			case (s % 4)
				0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin sender_idle_pct = 75; recv_stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  recv_stall_pct = 75; end
				default: begin sender_idle_pct = 24; recv_stall_pct = 24; end
			endcase
			// back the block up while the sender keeps pushing
			if (s == 0)
				hold_off_cycles = BACKPRESSURE_CYCLES;

			sent = 0;
			while (sent < EVENTS_PER_SETTING) begin
				case ($urandom_range(19))
					0, 1, 2, 3, 4, 5, 6, 7: kind = FUNC_DOWN;
					8, 9, 10, 11, 12, 13, 14: kind = FUNC_UP;
					15, 16, 17, 18: kind = FUNC_EMIT;
					default: kind = FUNC_UNUSED;
				endcase
				// time mostly walks forward on the scale of the windows;
				// now and then it jumps, runs backward or sits near the wrap
				case ($urandom_range(9))
					0, 1, 2, 3, 4:
						cursor_ns = cursor_ns + TIME_W'($urandom_range(0, span));
					5, 6: cursor_ns = cursor_ns + TIME_W'($urandom_range(0, 3));
					7: cursor_ns = {$urandom, $urandom};
					8: cursor_ns = cursor_ns - TIME_W'($urandom_range(0, span));
					default: cursor_ns = 64'hFFFF_FFFF_FFFF_FFFF
						- TIME_W'($urandom_range(0, span));
				endcase
				offer_event(kind, cursor_ns, 1'b0, NO_WANT);
				if (kind != FUNC_UNUSED)
					sent++;
			end
			settle();
		end

		$display("Run covered %0d event beats and %0d result beats over %0d register settings,",
			events_taken, outcomes_checked, SETTINGS_RUN + 2);
		$display("with idle and stalled phases on both channels and one long result hold-off.");
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

@@ button_release_debouncer_top.f @@
+incdir+design
design/brd_pkg.sv
design/brd_cfg.sv
design/brd_core.sv
design/button_release_debouncer_top.sv
verif/button_release_debouncer_top_test.sv
